/* rtl/sound_channel_allocator_core_assert.svh */
// Assertion macros shared by the sound channel allocator RTL.
`ifndef SOUND_CHANNEL_ALLOCATOR_CORE_ASSERT_SVH
`define SOUND_CHANNEL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SCA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sca_pkg.sv */
// Types and constants of the sound channel allocator.
`timescale 1ns / 1ps
`default_nettype none

package sca_pkg;

   // field widths
   localparam int CMD_W     = 3;
   localparam int ORIGIN_W  = 16;
   localparam int SOUND_W   = 10;
   localparam int PRIO_W    = 8;
   localparam int CHAN_W    = 4;
   localparam int STATUS_W  = 2;
   localparam int ACTIVE_W  = 5;

   localparam int MAX_CHANNELS_DEF = 16;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   // stored word of one channel: origin, sound, priority
   localparam int ENTRY_W = ORIGIN_W + SOUND_W + PRIO_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_START   = 3'd0,
      CMD_STOP    = 3'd1,
      CMD_RELEASE = 3'd2,
      CMD_QUERY   = 3'd3,
      CMD_STOPALL = 3'd4
   } cmd_type;

   localparam logic [STATUS_W-1:0] ST_FREE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EVICT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   // scan pass being run by the sequencer
   typedef enum logic [5:0] {
      PH_PRE   = 6'b000001,
      PH_STOP  = 6'b000010,
      PH_FIND  = 6'b000100,
      PH_EVICT = 6'b001000,
      PH_QUERY = 6'b010000,
      PH_CLEAR = 6'b100000
   } phase_type;

endpackage

`default_nettype wire

/* rtl/sound_channel_allocator_core.sv */
// Sound channel allocator: channel table with priority voice stealing.
// Release and unknown commands go straight to the result; scans run one channel per cycle
// through the table memory: query, stop and stop all in one pass, start in the pre, find and,
// if no channel is free, evict passes. One word in flight: the next word is taken the cycle
// after the result enters the output register. Synchronous reset frees all channels and sets
// the count to 16; a count write also frees all channels.
`timescale 1ns / 1ps
`default_nettype none

module sound_channel_allocator_core
   import sca_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   input  wire  logic                 req_valid,
   output logic                       req_stall,
   input  wire  logic [CMD_W-1:0]     req_cmd,
   input  wire  logic [ORIGIN_W-1:0]  req_origin_id,
   input  wire  logic [SOUND_W-1:0]   req_sound_id,
   input  wire  logic [PRIO_W-1:0]    req_priority_req,
   input  wire  logic [CHAN_W-1:0]    req_channel,
   output logic                       rsp_valid,
   input  wire  logic                 rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [CHAN_W-1:0]          rsp_channel_out,
   output logic                       rsp_hit,
   input  wire  logic                 csr_we,
   input  wire  logic [ACTIVE_W-1:0]  csr_wdata
);

   `include "sound_channel_allocator_core_assert.svh"

   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

   state_type                 state_ff, state_in;
   phase_type                 phase_ff, phase_in;
   logic [CNT_W-1:0]          iss_ff, iss_in;
   logic                      chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]          chk_idx_ff, chk_idx_in;
   logic [MAX_CHANNELS-1:0]   busy_ff, busy_in;
   logic [ACTIVE_W-1:0]       active_ff, active_in;
   logic [ORIGIN_W-1:0]       origin_ff, origin_in;
   logic [SOUND_W-1:0]        sound_ff, sound_in;
   logic [PRIO_W-1:0]         prio_ff, prio_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [CHAN_W-1:0]         res_ch_ff, res_ch_in;
   logic                      res_hit_ff, res_hit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [CHAN_W-1:0]         rsp_ch_ff, rsp_ch_in;
   logic                      rsp_hit_ff, rsp_hit_in;

   // channel table memory, one registered read port
   logic [ENTRY_W-1:0]        mem [MAX_CHANNELS];
   logic [ENTRY_W-1:0]        rd_data_ff;
   logic                      mem_we;

   logic [CNT_W-1:0]          n_c;
   logic [CMP_W-1:0]          active_ext;
   logic                      issue;
   logic                      exhausted;
   logic                      chk_busy;
   logic [ORIGIN_W-1:0]       m_origin;
   logic [SOUND_W-1:0]        m_sound;
   logic [PRIO_W-1:0]         m_prio;
   logic                      org_match;
   logic                      snd_match;
   logic                      match;
   logic                      rel_hit;
   logic [MAX_CHANNELS-1:0]   rel_clear;

   // terms for the checks
   logic                      grant_pass;
   logic                      chk_in_range;
   logic                      grant_now;
   logic                      grant_marked;

   // clamp channel count into 1..MAX_CHANNELS
   assign active_ext = CMP_W'(active_ff);
   always_comb begin
      if (active_ff == '0) begin
         n_c = CNT_W'(1);
      end else if (active_ext > CMP_W'(MAX_CHANNELS)) begin
         n_c = CNT_W'(MAX_CHANNELS);
      end else begin
         n_c = CNT_W'(active_ext);
      end
   end

   // scan compare on the checked channel
   assign m_origin  = rd_data_ff[ENTRY_W-1 -: ORIGIN_W];
   assign m_sound   = rd_data_ff[PRIO_W +: SOUND_W];
   assign m_prio    = rd_data_ff[PRIO_W-1:0];
   assign chk_busy  = busy_ff[chk_idx_ff];
   assign org_match = (origin_ff != '0) && (m_origin == origin_ff);
   assign snd_match = (sound_ff != '0) && (m_sound == sound_ff);
   assign issue     = (iss_ff < n_c);
   assign exhausted = !chk_vld_ff && !issue;

   always_comb begin
      unique case (phase_ff)
         PH_PRE, PH_STOP: match = chk_busy && org_match;
         PH_FIND:         match = !chk_busy || org_match;
         PH_EVICT:        match = chk_busy && (m_prio >= prio_ff);
         PH_QUERY:        match = chk_busy && (org_match || snd_match);
         default:         match = 1'b0;
      endcase
   end

   // release lookup on the busy bits
   always_comb begin
      rel_hit   = 1'b0;
      rel_clear = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         if ((32'(req_channel) == i) && (i < 32'(n_c)) && busy_ff[i]) begin
            rel_clear[i] = 1'b1;
            rel_hit      = 1'b1;
         end
      end
   end

   // sequencer and result path
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      iss_in        = iss_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      busy_in       = busy_ff;
      active_in     = active_ff;
      origin_in     = origin_ff;
      sound_in      = sound_ff;
      prio_in       = prio_ff;
      res_status_in = res_status_ff;
      res_ch_in     = res_ch_ff;
      res_hit_in    = res_hit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_hit_in    = rsp_hit_ff;
      mem_we        = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               origin_in     = req_origin_id;
               sound_in      = req_sound_id;
               prio_in       = req_priority_req;
               iss_in        = '0;
               chk_vld_in    = 1'b0;
               res_status_in = ST_DONE;
               res_ch_in     = '0;
               res_hit_in    = 1'b0;
               state_in      = S_SCAN;
               unique case (cmd_type'(req_cmd))
                  CMD_START:   phase_in = PH_PRE;
                  CMD_STOP:    phase_in = PH_STOP;
                  CMD_QUERY:   phase_in = PH_QUERY;
                  CMD_STOPALL: phase_in = PH_CLEAR;
                  CMD_RELEASE: begin
                     busy_in    = busy_ff & ~rel_clear;
                     res_ch_in  = req_channel;
                     res_hit_in = rel_hit;
                     state_in   = S_OUT;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end

         S_SCAN: begin
            // issue stage: read next channel
            chk_vld_in = issue;
            chk_idx_in = iss_ff[IDX_W-1:0];
            if (issue) begin
               iss_in = CNT_W'(iss_ff + 1'b1);
            end

            if (phase_ff == PH_CLEAR) begin
               // stop all: sweep every channel
               if (chk_vld_ff && chk_busy) begin
                  busy_in[chk_idx_ff] = 1'b0;
                  res_hit_in          = 1'b1;
               end
               if (exhausted) begin
                  state_in = S_OUT;
               end
            end else if (chk_vld_ff && match) begin
               iss_in     = '0;
               chk_vld_in = 1'b0;
               unique case (phase_ff)
                  PH_PRE: begin
                     busy_in[chk_idx_ff] = 1'b0;
                     phase_in            = PH_FIND;
                  end
                  PH_STOP: begin
                     busy_in[chk_idx_ff] = 1'b0;
                     res_hit_in          = 1'b1;
                     res_ch_in           = CHAN_W'(chk_idx_ff);
                     state_in            = S_OUT;
                  end
                  PH_FIND, PH_EVICT: begin
                     mem_we              = 1'b1;
                     busy_in[chk_idx_ff] = 1'b1;
                     res_status_in       = (phase_ff == PH_FIND) ? ST_FREE : ST_EVICT;
                     res_ch_in           = CHAN_W'(chk_idx_ff);
                     state_in            = S_OUT;
                  end
                  default: begin
                     res_hit_in = 1'b1;
                     state_in   = S_OUT;
                  end
               endcase
            end else if (exhausted) begin
               iss_in = '0;
               unique case (phase_ff)
                  PH_PRE:   phase_in = PH_FIND;
                  PH_FIND:  phase_in = PH_EVICT;
                  PH_EVICT: begin
                     res_status_in = ST_REFUSED;
                     state_in      = S_OUT;
                  end
                  default:  state_in = S_OUT;
               endcase
            end
         end

         S_OUT: begin
            // hand result to output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_ch_in     = res_ch_ff;
               rsp_hit_in    = res_hit_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // channel count write frees the table
      if (csr_we) begin
         active_in = csr_wdata;
         busy_in   = '0;
      end
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_PRE;
         iss_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         busy_ff      <= '0;
         active_ff    <= ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         iss_ff       <= iss_in;
         chk_vld_ff   <= chk_vld_in;
         busy_ff      <= busy_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_idx_ff    <= chk_idx_in;
      origin_ff     <= origin_in;
      sound_ff      <= sound_in;
      prio_ff       <= prio_in;
      res_status_ff <= res_status_in;
      res_ch_ff     <= res_ch_in;
      res_hit_ff    <= res_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   // table memory: write on grant, read at issue index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[chk_idx_ff] <= {origin_ff, sound_ff, prio_ff};
      end
      rd_data_ff <= mem[iss_ff[IDX_W-1:0]];
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_channel_out = rsp_ch_ff;
   assign rsp_hit         = rsp_hit_ff;

   // checks
   assign grant_pass   = (state_ff == S_SCAN) && (phase_ff == PH_FIND || phase_ff == PH_EVICT);
   assign chk_in_range = (CNT_W'(chk_idx_ff) < n_c);
   assign grant_now    = mem_we && !csr_we;
   assign grant_marked = busy_ff[IDX_W'(res_ch_ff)] && (state_ff == S_OUT);

   `SCA_ASSERT_NOW(a_grant_phase, clock, reset, mem_we, grant_pass, "write outside a grant pass")
   `SCA_ASSERT_NOW(a_chk_range, clock, reset, chk_vld_ff, chk_in_range, "channel beyond count")
   `SCA_ASSERT_NEXT(a_grant_busy, clock, reset, grant_now, grant_marked, "grant not marked busy")

endmodule

`default_nettype wire
